FILE: rtl/core/pi_motor_velocity_controller_unit_defines.svh
// Assertion macros shared by the velocity controller RTL.
// Included by files that check their own logic; needs nothing else.
`ifndef PI_MOTOR_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`define PI_MOTOR_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PMVC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is low.
`define PMVC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

FILE: rtl/core/pmvc_pkg.sv
// Shared constants, types and the control program of the velocity controller.
// Used by every module of the block; depends on nothing.
package pmvc_pkg;

  localparam int TICKS_PER_SECOND = 50;
  localparam int FRAC_BITS        = 8;
  localparam int DUTY_BITS        = 11;
  localparam int WGT_FRAC         = 8;
  localparam int GAIN_FRAC        = 8;

  localparam int CNT_W   = 32;
  localparam int VAL_W   = 29;
  localparam int GAIN_W  = 16;
  localparam int WGT_W   = 9;
  localparam int LIM_W   = 28;
  localparam int CFG_W   = 29;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 48;
  localparam int Y_W    = 30;
  localparam int TS_W   = 32;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_FIELD_W = DUTY_BITS + 1 + 5 * VAL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam longint VAL_MAX = (longint'(1) << (VAL_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) << (VAL_W - 1));

  localparam logic signed [PROD_W-1:0] RAW_PMAX = PROD_W'(VAL_MAX >>> FRAC_BITS);
  localparam logic signed [PROD_W-1:0] RAW_PMIN =
    PROD_W'(-((longint'(1) << (VAL_W - 1)) >>> FRAC_BITS));

  // Floor division by the tick rate: bias to a positive value, multiply by the
  // reciprocal, then correct the estimate by at most one.
  localparam int     DIV_SHIFT       = 32;
  localparam longint DIV_RECIP_FULL  = (longint'(1) << DIV_SHIFT) / TICKS_PER_SECOND;
  localparam longint DIV_RECIP_MAX   = (longint'(1) << DIV_SHIFT) - 1;
  localparam longint DIV_RECIP       =
    (DIV_RECIP_FULL > DIV_RECIP_MAX) ? DIV_RECIP_MAX : DIV_RECIP_FULL;
  localparam longint DIV_BIAS_Q      =
    ((longint'(1) << (VAL_W - 1)) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam longint DIV_BIAS        = DIV_BIAS_Q * TICKS_PER_SECOND;

  localparam logic signed [MUL_W-1:0] MUL_TPS   = MUL_W'(TICKS_PER_SECOND);
  localparam logic signed [MUL_W-1:0] MUL_RECIP = MUL_W'(DIV_RECIP);

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] setpoint_speed;
    logic [GAIN_W-1:0]       proportional_gain;
    logic [GAIN_W-1:0]       integral_gain;
    logic [WGT_W-1:0]        smoothing_weight;
    logic [LIM_W-1:0]        integral_limit;
    logic [LIM_W-1:0]        overspeed_margin;
    logic [DUTY_BITS-1:0]    duty_floor;
    logic [DUTY_BITS-1:0]    duty_ceiling;
  } cfg_t;

  localparam int ALU_W = 4;
  localparam logic [ALU_W-1:0] ALU_NOP      = 4'd0;
  localparam logic [ALU_W-1:0] ALU_DIFF     = 4'd1;
  localparam logic [ALU_W-1:0] ALU_RAW      = 4'd2;
  localparam logic [ALU_W-1:0] ALU_ACC_LOAD = 4'd3;
  localparam logic [ALU_W-1:0] ALU_ACC_ADD  = 4'd4;
  localparam logic [ALU_W-1:0] ALU_AVG      = 4'd5;
  localparam logic [ALU_W-1:0] ALU_ERR      = 4'd6;
  localparam logic [ALU_W-1:0] ALU_OVS      = 4'd7;
  localparam logic [ALU_W-1:0] ALU_QEST     = 4'd8;
  localparam logic [ALU_W-1:0] ALU_QFIX     = 4'd9;
  localparam logic [ALU_W-1:0] ALU_ISUM     = 4'd10;
  localparam logic [ALU_W-1:0] ALU_ICLAMP   = 4'd11;
  localparam logic [ALU_W-1:0] ALU_DRIVE    = 4'd12;
  localparam logic [ALU_W-1:0] ALU_EMIT     = 4'd13;
  localparam logic [ALU_W-1:0] ALU_CLEAR    = 4'd14;

  localparam int MSEL_W = 3;
  localparam logic [MSEL_W-1:0] MUL_NONE     = 3'd0;
  localparam logic [MSEL_W-1:0] MUL_D_TPS    = 3'd1;
  localparam logic [MSEL_W-1:0] MUL_AVG_WINV = 3'd2;
  localparam logic [MSEL_W-1:0] MUL_RAW_W    = 3'd3;
  localparam logic [MSEL_W-1:0] MUL_Y_RECIP  = 3'd4;
  localparam logic [MSEL_W-1:0] MUL_Q_TPS    = 3'd5;
  localparam logic [MSEL_W-1:0] MUL_ERR_KP   = 3'd6;
  localparam logic [MSEL_W-1:0] MUL_INT_KI   = 3'd7;

  localparam int BR_W = 2;
  localparam logic [BR_W-1:0] BR_NEXT    = 2'd0;
  localparam logic [BR_W-1:0] BR_WAIT_IN = 2'd1;
  localparam logic [BR_W-1:0] BR_KIND    = 2'd2;
  localparam logic [BR_W-1:0] BR_ALWAYS  = 2'd3;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] PC_START = 5'd19;

  typedef struct packed {
    logic [ALU_W-1:0]  alu;
    logic [MSEL_W-1:0] mul;
  } dp_ctl_t;

  typedef struct packed {
    logic [ALU_W-1:0]  alu;
    logic [MSEL_W-1:0] mul;
    logic [BR_W-1:0]   br;
    logic [PC_W-1:0]   target;
    logic              emit;
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '{alu: ALU_NOP, mul: MUL_NONE, br: BR_ALWAYS, target: PC_IDLE, emit: 1'b0};
    case (pc)
      5'd0:  c = '{alu: ALU_NOP,      mul: MUL_NONE,     br: BR_WAIT_IN,
                   target: PC_IDLE, emit: 1'b0};
      5'd1:  c = '{alu: ALU_DIFF,     mul: MUL_NONE,     br: BR_KIND,
                   target: PC_START, emit: 1'b0};
      5'd2:  c = '{alu: ALU_NOP,      mul: MUL_D_TPS,    br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd3:  c = '{alu: ALU_RAW,      mul: MUL_AVG_WINV, br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd4:  c = '{alu: ALU_ACC_LOAD, mul: MUL_RAW_W,    br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd5:  c = '{alu: ALU_ACC_ADD,  mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd6:  c = '{alu: ALU_AVG,      mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd7:  c = '{alu: ALU_ERR,      mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd8:  c = '{alu: ALU_OVS,      mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd9:  c = '{alu: ALU_NOP,      mul: MUL_Y_RECIP,  br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd10: c = '{alu: ALU_QEST,     mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd11: c = '{alu: ALU_NOP,      mul: MUL_Q_TPS,    br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd12: c = '{alu: ALU_QFIX,     mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd13: c = '{alu: ALU_ISUM,     mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd14: c = '{alu: ALU_ICLAMP,   mul: MUL_ERR_KP,   br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd15: c = '{alu: ALU_ACC_LOAD, mul: MUL_INT_KI,   br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd16: c = '{alu: ALU_ACC_ADD,  mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd17: c = '{alu: ALU_DRIVE,    mul: MUL_NONE,     br: BR_NEXT,
                   target: PC_IDLE, emit: 1'b0};
      5'd18: c = '{alu: ALU_EMIT,     mul: MUL_NONE,     br: BR_ALWAYS,
                   target: PC_IDLE, emit: 1'b1};
      5'd19: c = '{alu: ALU_CLEAR,    mul: MUL_NONE,     br: BR_ALWAYS,
                   target: PC_IDLE, emit: 1'b0};
      default: c = '{alu: ALU_NOP,    mul: MUL_NONE,     br: BR_ALWAYS,
                     target: PC_IDLE, emit: 1'b0};
    endcase
    return c;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(VAL_MAX);
    lo = ACC_W'(VAL_MIN);
    if (v > hi) begin
      return hi[VAL_W-1:0];
    end else if (v < lo) begin
      return lo[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/pi_motor_velocity_controller_unit.sv
// Top level of the PI velocity controller: config registers, sequencer, datapath.
// Depends on pmvc_pkg, pmvc_cfg, pmvc_seq, pmvc_dp and the assertion macros.
//
//   Channel  Direction  Handshake            Contents
//   in_      slave      tvalid/tready        tuser: kind; tdata: encoder_count
//   out_     master     tvalid/tready        tdata: duty .. drive_value
//   cfg_     write      cfg_wr_en            cfg_addr selects, cfg_wdata holds value
//
// A control tick's result is registered at the last step of the 18-step tick
// program around one shared 33x33 multiplier. A start item runs the clear step
// and gives no result. A new item is accepted only in the idle step, so a new
// tick waits until the last one is through; a result waiting at the output
// stalls the sequencer at its last step.
// Reset is synchronous and active low; it clears the step counter, the controller
// state and the output valid, and loads the register defaults.
`include "pi_motor_velocity_controller_unit_defines.svh"

module pi_motor_velocity_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] encoder_count
  input  logic [pmvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] kind
  input  logic [pmvc_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [10:0] duty, [11] reverse, [40:12] raw_speed, [69:41] smoothed_speed,
  // [98:70] speed_error, [127:99] integral_value, [156:128] drive_value
  output logic [pmvc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [pmvc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pmvc_pkg::CFG_W-1:0]        cfg_wdata
);
  import pmvc_pkg::*;

  cfg_t    cfg;
  dp_ctl_t dp_ctl;
  logic    kind;
  logic    out_busy;
  logic    in_acc;

  assign in_acc = in_tvalid && in_tready;

  pmvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  pmvc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .kind      (kind),
    .out_busy  (out_busy),
    .in_tready (in_tready),
    .dp_ctl    (dp_ctl)
  );

  pmvc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .dp_ctl     (dp_ctl),
    .cfg        (cfg),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .kind       (kind),
    .out_busy   (out_busy)
  );

  `PMVC_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PMVC_ASSERT_IMPL(a_result_from_emit, clk, rst_n, $rose(out_tvalid), $past(dp_ctl.alu == ALU_EMIT))
  `PMVC_ASSERT_IMPL(a_duty_under_ceiling, clk, rst_n, out_tvalid, out_tdata[DUTY_BITS-1:0] <= cfg.duty_ceiling)

endmodule

FILE: rtl/core/pmvc_cfg.sv
// Configuration register file of the velocity controller.
// Depends on pmvc_pkg for widths and register indexes; the reset values are set here.
module pmvc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pmvc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pmvc_pkg::CFG_W-1:0]      cfg_wdata,
  output pmvc_pkg::cfg_t                  cfg_o
);
  import pmvc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SETPOINT: cfg_nxt.setpoint_speed    = $signed(cfg_wdata[VAL_W-1:0]);
        REG_KP:       cfg_nxt.proportional_gain = cfg_wdata[GAIN_W-1:0];
        REG_KI:       cfg_nxt.integral_gain     = cfg_wdata[GAIN_W-1:0];
        REG_WEIGHT:   cfg_nxt.smoothing_weight  = cfg_wdata[WGT_W-1:0];
        REG_ILIMIT:   cfg_nxt.integral_limit    = cfg_wdata[LIM_W-1:0];
        REG_MARGIN:   cfg_nxt.overspeed_margin  = cfg_wdata[LIM_W-1:0];
        REG_FLOOR:    cfg_nxt.duty_floor        = cfg_wdata[DUTY_BITS-1:0];
        REG_CEILING:  cfg_nxt.duty_ceiling      = cfg_wdata[DUTY_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_speed    <= VAL_W'(465152);
      cfg_r.proportional_gain <= GAIN_W'(26);
      cfg_r.integral_gain     <= GAIN_W'(256);
      cfg_r.smoothing_weight  <= WGT_W'(51);
      cfg_r.integral_limit    <= LIM_W'(1280000);
      cfg_r.overspeed_margin  <= LIM_W'(12800);
      cfg_r.duty_floor        <= DUTY_BITS'(365);
      cfg_r.duty_ceiling      <= DUTY_BITS'(2047);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: rtl/core/pmvc_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on pmvc_pkg for the control word layout and the program.
module pmvc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               kind,
  input  logic               out_busy,
  output logic               in_tready,
  output pmvc_pkg::dp_ctl_t  dp_ctl
);
  import pmvc_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctl_t            uw;
  logic            stall;

  assign uw        = ucode(pc_r);
  assign stall     = uw.emit && out_busy;
  assign in_tready = (pc_r == PC_IDLE);

  always_comb begin
    pc_nxt = pc_r;
    if (!stall) begin
      case (uw.br)
        BR_NEXT:    pc_nxt = pc_r + PC_W'(1);
        BR_WAIT_IN: pc_nxt = in_tvalid ? pc_r + PC_W'(1) : pc_r;
        BR_KIND:    pc_nxt = kind ? uw.target : pc_r + PC_W'(1);
        BR_ALWAYS:  pc_nxt = uw.target;
        default:    pc_nxt = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign dp_ctl.alu = stall ? ALU_NOP : uw.alu;
  assign dp_ctl.mul = stall ? MUL_NONE : uw.mul;

endmodule

FILE: rtl/core/pmvc_dp.sv
// Datapath of the velocity controller: shared multiplier, accumulator, ALU
// steps, controller state and the output register. Depends on pmvc_pkg.
module pmvc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_acc,
  input  logic [pmvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [pmvc_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  pmvc_pkg::dp_ctl_t                 dp_ctl,
  input  pmvc_pkg::cfg_t                    cfg,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [pmvc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              kind,
  output logic                              out_busy
);
  import pmvc_pkg::*;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      kind_r, kind_nxt;
  logic [CNT_W-1:0]          prev_r, prev_nxt;
  logic signed [CNT_W-1:0]   d_r, d_nxt;
  logic signed [VAL_W-1:0]   raw_r, raw_nxt;
  logic signed [VAL_W-1:0]   avg_r, avg_nxt;
  logic signed [VAL_W-1:0]   err_r, err_nxt;
  logic signed [VAL_W-1:0]   integ_r, integ_nxt;
  logic signed [VAL_W-1:0]   drive_r, drive_nxt;
  logic                      ovs_r, ovs_nxt;
  logic [Y_W-1:0]            y_r, y_nxt;
  logic [Y_W-1:0]            q_r, q_nxt;
  logic signed [TS_W-1:0]    tsum_r, tsum_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [OUT_TDATA_W-1:0]    odata_r, odata_nxt;
  logic                      ovalid_r, ovalid_nxt;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [WGT_W-1:0]          w_cap, w_inv;
  logic signed [VAL_W:0]     diff_e;
  logic [VAL_W-1:0]          sp_mag, avg_mag, drv_mag;
  logic [VAL_W:0]            ovs_lhs;
  logic signed [Y_W:0]       y_full;
  logic [Y_W:0]              rem;
  logic signed [TS_W-1:0]    lim_pos, lim_neg;
  logic [VAL_W-1:0]          duty_full;
  logic [VAL_W-1:0]          duty_sel;

  assign w_cap = (cfg.smoothing_weight > WGT_W'(256)) ? WGT_W'(256) : cfg.smoothing_weight;
  assign w_inv = WGT_W'(256) - w_cap;

  always_comb begin
    case (dp_ctl.mul)
      MUL_D_TPS: begin
        mul_a = {{(MUL_W-CNT_W){d_r[CNT_W-1]}}, d_r};
        mul_b = MUL_TPS;
      end
      MUL_AVG_WINV: begin
        mul_a = {{(MUL_W-VAL_W){avg_r[VAL_W-1]}}, avg_r};
        mul_b = {{(MUL_W-WGT_W){1'b0}}, w_inv};
      end
      MUL_RAW_W: begin
        mul_a = {{(MUL_W-VAL_W){raw_r[VAL_W-1]}}, raw_r};
        mul_b = {{(MUL_W-WGT_W){1'b0}}, w_cap};
      end
      MUL_Y_RECIP: begin
        mul_a = {{(MUL_W-Y_W){1'b0}}, y_r};
        mul_b = MUL_RECIP;
      end
      MUL_Q_TPS: begin
        mul_a = {{(MUL_W-Y_W){1'b0}}, q_r};
        mul_b = MUL_TPS;
      end
      MUL_ERR_KP: begin
        mul_a = {{(MUL_W-VAL_W){err_r[VAL_W-1]}}, err_r};
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.proportional_gain};
      end
      MUL_INT_KI: begin
        mul_a = {{(MUL_W-VAL_W){integ_r[VAL_W-1]}}, integ_r};
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.integral_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign diff_e  = {cfg.setpoint_speed[VAL_W-1], cfg.setpoint_speed}
                 - {avg_r[VAL_W-1], avg_r};
  assign sp_mag  = cfg.setpoint_speed[VAL_W-1] ? (~cfg.setpoint_speed + VAL_W'(1))
                                               : cfg.setpoint_speed;
  assign avg_mag = avg_r[VAL_W-1] ? (~avg_r + VAL_W'(1)) : avg_r;
  assign drv_mag = drive_r[VAL_W-1] ? (~drive_r + VAL_W'(1)) : drive_r;
  assign ovs_lhs = {1'b0, sp_mag} + {{(VAL_W+1-LIM_W){1'b0}}, cfg.overspeed_margin};
  assign y_full  = {{(Y_W+1-VAL_W){err_r[VAL_W-1]}}, err_r} + (Y_W+1)'(DIV_BIAS);
  assign rem     = {1'b0, y_r} - prod_r[Y_W:0];
  assign lim_pos = {{(TS_W-LIM_W){1'b0}}, cfg.integral_limit};
  assign lim_neg = -lim_pos;
  assign duty_full = drv_mag >> FRAC_BITS;

  always_comb begin
    duty_sel = duty_full;
    if (duty_sel < VAL_W'(cfg.duty_floor)) begin
      duty_sel = VAL_W'(cfg.duty_floor);
    end
    if (duty_sel > VAL_W'(cfg.duty_ceiling)) begin
      duty_sel = VAL_W'(cfg.duty_ceiling);
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    kind_nxt   = kind_r;
    prev_nxt   = prev_r;
    d_nxt      = d_r;
    raw_nxt    = raw_r;
    avg_nxt    = avg_r;
    err_nxt    = err_r;
    integ_nxt  = integ_r;
    drive_nxt  = drive_r;
    ovs_nxt    = ovs_r;
    y_nxt      = y_r;
    q_nxt      = q_r;
    tsum_nxt   = tsum_r;
    acc_nxt    = acc_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r;
    prod_nxt   = (dp_ctl.mul == MUL_NONE) ? prod_r : mul_a * mul_b;

    if (in_acc) begin
      cnt_nxt  = in_tdata[CNT_W-1:0];
      kind_nxt = in_tuser[0];
    end
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (dp_ctl.alu)
      ALU_DIFF: begin
        d_nxt    = $signed(cnt_r - prev_r);
        prev_nxt = cnt_r;
      end
      ALU_RAW: begin
        if (prod_r > RAW_PMAX) begin
          raw_nxt = VAL_W'(VAL_MAX);
        end else if (prod_r < RAW_PMIN) begin
          raw_nxt = VAL_W'(VAL_MIN);
        end else begin
          raw_nxt = {prod_r[VAL_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end
      end
      ALU_ACC_LOAD: acc_nxt = $signed(prod_r[ACC_W-1:0]);
      ALU_ACC_ADD:  acc_nxt = acc_r + $signed(prod_r[ACC_W-1:0]);
      ALU_AVG:      avg_nxt = sat_val(acc_r >>> WGT_FRAC);
      ALU_ERR:      err_nxt = sat_val(ACC_W'(diff_e));
      ALU_OVS: begin
        ovs_nxt = ovs_lhs < {1'b0, avg_mag};
        y_nxt   = y_full[Y_W-1:0];
      end
      ALU_QEST: q_nxt = prod_r[DIV_SHIFT +: Y_W];
      ALU_QFIX: begin
        if (rem >= (Y_W+1)'(TICKS_PER_SECOND)) begin
          q_nxt = q_r + Y_W'(1);
        end
      end
      ALU_ISUM: begin
        tsum_nxt = {{(TS_W-VAL_W){integ_r[VAL_W-1]}}, integ_r}
                 + $signed({{(TS_W-Y_W){1'b0}}, q_r})
                 - TS_W'(DIV_BIAS_Q);
      end
      ALU_ICLAMP: begin
        if (ovs_r) begin
          integ_nxt = '0;
        end else if (tsum_r > lim_pos) begin
          integ_nxt = lim_pos[VAL_W-1:0];
        end else if (tsum_r < lim_neg) begin
          integ_nxt = lim_neg[VAL_W-1:0];
        end else begin
          integ_nxt = tsum_r[VAL_W-1:0];
        end
      end
      ALU_DRIVE: drive_nxt = sat_val(acc_r >>> GAIN_FRAC);
      ALU_EMIT: begin
        odata_nxt  = {{OUT_PAD_W{1'b0}}, drive_r, integ_r, err_r, avg_r, raw_r,
                      drive_r[VAL_W-1], duty_sel[DUTY_BITS-1:0]};
        ovalid_nxt = 1'b1;
      end
      ALU_CLEAR: begin
        avg_nxt   = '0;
        integ_nxt = '0;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= 1'b0;
      prev_r   <= '0;
      avg_r    <= '0;
      integ_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      kind_r   <= kind_nxt;
      prev_r   <= prev_nxt;
      avg_r    <= avg_nxt;
      integ_r  <= integ_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    d_r     <= d_nxt;
    raw_r   <= raw_nxt;
    err_r   <= err_nxt;
    drive_r <= drive_nxt;
    ovs_r   <= ovs_nxt;
    y_r     <= y_nxt;
    q_r     <= q_nxt;
    tsum_r  <= tsum_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign kind       = kind_r;
  assign out_busy   = ovalid_r && !out_tready;

endmodule
